@@ sv/hvt_pkg.sv @@
// Shared types and constants for the homogeneous vertex transform core.
`default_nettype none

package hvt_pkg;

  localparam int unsigned DIM     = 4;              // matrix rows and columns
  localparam int unsigned NVEC    = DIM - 1;        // explicit point components
  localparam int unsigned DW      = 32;             // data width of every value
  localparam int unsigned IDX_W   = $clog2(DIM);    // row or column select
  localparam int unsigned CHAIN_D = 2 * DIM;        // pipeline registers in the chain

  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } hvt_cmd_e;

  typedef struct packed {
    hvt_cmd_e                 command;
    logic [2*IDX_W-1:0]       entry_index;
    logic signed [DW-1:0]     entry_value;
    logic signed [DW-1:0]     vec_x;
    logic signed [DW-1:0]     vec_y;
    logic signed [DW-1:0]     vec_z;
  } hvt_req_t;

  typedef struct packed {
    logic signed [DW-1:0]     out_x;
    logic signed [DW-1:0]     out_y;
    logic signed [DW-1:0]     out_z;
    logic signed [DW-1:0]     out_w;
    logic                     saturated;
  } hvt_rsp_t;

  // What moves from cell to cell: the request plus the rows finished so far.
  typedef struct packed {
    hvt_req_t                 req;
    logic [DIM-1:0][DW-1:0]   res;
    logic [DIM-1:0]           clip;
  } hvt_tok_t;

endpackage

`default_nettype wire

@@ sv/hvt_cell.sv @@
// One matrix row: holds the row, multiplies it with the passing point, sums and saturates.
`default_nettype none

module hvt_cell import hvt_pkg::*; #(
  parameter int unsigned ROW       = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire hvt_tok_t in_tok_i,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  output      hvt_tok_t out_tok_o
);

  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW - FRAC_BITS + 2;
  localparam logic [IDX_W-1:0] ROW_SEL = IDX_W'(ROW);

  logic signed [DW-1:0] row_q   [DIM];
  logic signed [DW-1:0] vec     [NVEC];

  logic                 p_valid_q;
  hvt_tok_t             p_tok_q;
  logic signed [PW-1:0] prod_q  [NVEC];
  logic signed [DW-1:0] wterm_q;

  logic                 s_valid_q;
  hvt_tok_t             s_tok_q, s_tok_d;

  logic                 p_ready, s_ready, p_load, s_load, row_wr;
  logic signed [SW-1:0] sum;
  logic                 pos_ovf, neg_ovf;
  logic [DW-1:0]        sat_val;

  assign s_ready    = !s_valid_q || out_ready_i;
  assign p_ready    = !p_valid_q || s_ready;
  assign in_ready_o = p_ready;
  assign p_load     = in_valid_i && p_ready;
  assign s_load     = p_valid_q && s_ready;

  assign row_wr = p_load && (in_tok_i.req.command == CMD_LOAD) &&
                  (in_tok_i.req.entry_index[2*IDX_W-1:IDX_W] == ROW_SEL);

  assign vec[0] = in_tok_i.req.vec_x;
  assign vec[1] = in_tok_i.req.vec_y;
  assign vec[2] = in_tok_i.req.vec_z;

  // Row storage; a load writes as it passes this cell, so order with transforms holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) row_q[i] <= '0;
    end else if (row_wr) begin
      row_q[in_tok_i.req.entry_index[IDX_W-1:0]] <= in_tok_i.req.entry_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (p_ready) p_valid_q <= in_valid_i;
      if (s_ready) s_valid_q <= p_valid_q;
    end
  end

  // Product stage. w is exactly one, so its term is the entry itself.
  always_ff @(posedge clk_i) begin
    if (p_load) begin
      p_tok_q <= in_tok_i;
      for (int c = 0; c < NVEC; c++) prod_q[c] <= PW'(row_q[c]) * PW'(vec[c]);
      wterm_q <= row_q[DIM-1];
    end
  end

  // Floor-shifted products summed exactly, then clipped to 32 bits.
  always_comb begin
    sum = SW'(wterm_q);
    for (int c = 0; c < NVEC; c++) sum = sum + SW'(prod_q[c] >>> FRAC_BITS);
    pos_ovf = !sum[SW-1] && (|sum[SW-2:DW-1]);
    neg_ovf =  sum[SW-1] && !(&sum[SW-2:DW-1]);
    if (pos_ovf)      sat_val = SAT_MAX;
    else if (neg_ovf) sat_val = SAT_MIN;
    else              sat_val = sum[DW-1:0];
    s_tok_d           = p_tok_q;
    s_tok_d.res[ROW]  = sat_val;
    s_tok_d.clip[ROW] = pos_ovf || neg_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (s_load) begin
      s_tok_q <= s_tok_d;
    end
  end

  assign out_valid_o = s_valid_q;
  assign out_tok_o   = s_tok_q;

endmodule

`default_nettype wire

@@ sv/homogeneous_vertex_transform_core.sv @@
// Top level of the homogeneous vertex transform core: a chain of four row cells.
`default_nettype none

// Takes one request per clock while the chain has room and streams it through
// four row cells. A load request writes one entry of the 4x4 matrix (index =
// row * 4 + column) and produces no response; a transform request carries a
// point (x, y, z), is treated as (x, y, z, 1) and returns all four components
// of matrix times vector plus a saturation flag. All values are signed fixed
// point with FRAC_BITS fraction bits (Q16.16 by default). Each product is
// floored after the shift, each row sum is clipped to 32 bits. The matrix is
// all zero after reset. Throughput is one request per cycle while the chain has
// room; a transform response is offered once the request has passed both
// registers of every cell (products, then row sum; the first loads on the
// accepting edge), and waits longer only while the response side stalls.
// Each cell holds its own matrix row and applies loads as they pass, so loads
// and transforms always see the matrix in request order. Bubbles in the chain
// close up under backpressure, so requests keep being taken while a finished
// response waits to be taken, until all eight chain registers hold requests.

module homogeneous_vertex_transform_core import hvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output      logic     req_ready_o,
  input  wire hvt_req_t req_i,
  output      logic     rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output      hvt_rsp_t rsp_o
);

  logic     valid [DIM+1];
  logic     ready [DIM+1];
  hvt_tok_t tok   [DIM+1];

  // chain head: request enters with no rows done yet
  assign valid[0]     = req_valid_i;
  assign req_ready_o  = ready[0];
  assign tok[0].req   = req_i;
  assign tok[0].res   = '0;
  assign tok[0].clip  = '0;

  for (genvar r = 0; r < DIM; r++) begin : g_cell
    hvt_cell #(
      .ROW       (r),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[r]),
      .in_ready_o  (ready[r]),
      .in_tok_i    (tok[r]),
      .out_valid_o (valid[r+1]),
      .out_ready_i (ready[r+1]),
      .out_tok_o   (tok[r+1])
    );
  end

  // Loads drain silently off the chain end; transforms wait for the consumer.
  assign rsp_valid_o = valid[DIM] && (tok[DIM].req.command == CMD_XFORM);
  assign ready[DIM]  = rsp_ready_i || (tok[DIM].req.command == CMD_LOAD);

  assign rsp_o.out_x     = tok[DIM].res[0];
  assign rsp_o.out_y     = tok[DIM].res[1];
  assign rsp_o.out_z     = tok[DIM].res[2];
  assign rsp_o.out_w     = tok[DIM].res[3];
  assign rsp_o.saturated = |tok[DIM].clip;

endmodule

`default_nettype wire

@@ sv/hvt_checker.sv @@
// Port-level checks for the vertex transform core, bound to the top level.
`default_nettype none

module hvt_checker import hvt_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     req_valid_i,
  input wire logic     req_ready_o,
  input wire hvt_req_t req_i,
  input wire logic     rsp_valid_o,
  input wire logic     rsp_ready_i,
  input wire hvt_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(CHAIN_D) + 2;

  logic [CNT_W-1:0] pending_q, pending_d;
  logic             xform_in, rsp_out;

  assign xform_in = req_valid_i && req_ready_o && (req_i.command == CMD_XFORM);
  assign rsp_out  = rsp_valid_o && rsp_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (xform_in) pending_d = pending_d + CNT_W'(1);
    if (rsp_out)  pending_d = pending_d - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("response dropped before it was taken");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (pending_q != '0))
    else $error("response without an outstanding transform request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CNT_W'(CHAIN_D))
    else $error("more transforms in flight than the chain holds");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.saturated |->
      (rsp_o.out_x == SAT_MAX) || (rsp_o.out_x == SAT_MIN) ||
      (rsp_o.out_y == SAT_MAX) || (rsp_o.out_y == SAT_MIN) ||
      (rsp_o.out_z == SAT_MAX) || (rsp_o.out_z == SAT_MIN) ||
      (rsp_o.out_w == SAT_MAX) || (rsp_o.out_w == SAT_MIN))
    else $error("saturation flagged but no component is at a limit");

endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (.*);

`default_nettype wire
